// ===== design/pdt_pkg.sv =====
// Shared constants and types for the prescaled down-timer register block.
`default_nettype none

package pdt_pkg;

    localparam int BASE_PERIOD = 128;
    localparam int PRESC_W     = $clog2(BASE_PERIOD * 64);
    localparam int PERIOD_W    = PRESC_W + 1;

    localparam logic [15:0] RELOAD_RESET = 16'h1200;
    localparam logic [15:0] COUNT_RESET  = 16'hFFFF;
    localparam logic [15:0] MODE_READ_HI = 16'hFF00;

    typedef enum logic [1:0] {
        OP_TICK       = 2'd0,
        OP_WORD_READ  = 2'd1,
        OP_WORD_WRITE = 2'd2,
        OP_BYTE_WRITE = 2'd3
    } op_t;

    localparam logic [2:0] OFF_RELOAD    = 3'd0;
    localparam logic [2:0] OFF_RELOAD_HI = 3'd1;
    localparam logic [2:0] OFF_COUNT     = 3'd2;
    localparam logic [2:0] OFF_MODE      = 3'd4;

    localparam int M_CONT   = 1;
    localparam int M_ENBEND = 2;
    localparam int M_ONCE   = 3;
    localparam int M_START  = 4;
    localparam int M_DIV16  = 5;
    localparam int M_DIV4   = 6;
    localparam int M_END    = 7;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [2:0]  offset;
        logic [15:0] write_data;
    } item_t;

    function automatic logic [PERIOD_W-1:0] period_of(input logic [7:0] m);
        logic [PERIOD_W-1:0] p;
        p = PERIOD_W'(BASE_PERIOD);
        if (m[M_DIV16]) p = p << 4;
        if (m[M_DIV4])  p = p << 2;
        return p;
    endfunction

endpackage

`default_nettype wire

// ===== design/prescaled_down_timer_registers.sv =====
// Top level: prescaled 16-bit down timer behind reload, count and mode registers.
// Each accepted input word goes from the input register to the result register.
// Throughput: one input word per cycle unless the output stalls; then both registers hold.
// The state update for each word is one pass of logic between those registers.
// Reset (aresetn low, synchronous): both registers empty, reload 0x1200,
// count 0xFFFF, mode 0, prescaler 0.
`default_nettype none

module prescaled_down_timer_registers (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [23:0] s_tdata,   // [2:0] offset, [18:3] write_data, [23:19] zero
    input  wire  [1:0]  s_tuser,   // [1:0] opcode
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [15:0] m_tdata,   // [15:0] read_data
    output logic        m_tuser    // [0] read_valid
);

    pdt_pkg::item_t in_reg;
    logic           in_valid_reg;
    logic           advance;

    logic [15:0] reload_reg, reload_next;
    logic [15:0] count_reg, count_next;
    logic [7:0]  mode_reg, mode_next;
    logic [pdt_pkg::PRESC_W-1:0] presc_reg, presc_next;

    logic [15:0] rdata_reg, rdata_next;
    logic        rvalid_reg, rvalid_next;
    logic        out_valid_reg;

    logic [pdt_pkg::PERIOD_W-1:0] presc_inc;
    logic [7:0]  new_mode;
    logic        mode_wr;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = rdata_reg;
    assign m_tuser  = rvalid_reg;

    assign presc_inc = {1'b0, presc_reg} + pdt_pkg::PERIOD_W'(1);
    assign new_mode  = in_reg.write_data[7:0];

    always_comb begin
        reload_next = reload_reg;
        count_next  = count_reg;
        mode_next   = mode_reg;
        presc_next  = presc_reg;
        rdata_next  = 16'h0000;
        rvalid_next = 1'b0;
        mode_wr     = 1'b0;
        case (pdt_pkg::op_t'(in_reg.opcode))
            pdt_pkg::OP_TICK: begin
                if (mode_reg[pdt_pkg::M_START]) begin
                    if (presc_inc >= pdt_pkg::period_of(mode_reg)) begin
                        presc_next = '0;
                        if (count_reg > 16'd1) begin
                            count_next = count_reg - 16'd1;
                        end else begin
                            if (mode_reg[pdt_pkg::M_ENBEND]) begin
                                mode_next[pdt_pkg::M_END] = 1'b1;
                            end
                            if (mode_reg[pdt_pkg::M_ONCE] && !mode_reg[pdt_pkg::M_CONT]) begin
                                count_next = 16'h0000;
                                mode_next[pdt_pkg::M_START] = 1'b0;
                            end else if (mode_reg[pdt_pkg::M_CONT]) begin
                                count_next = 16'hFFFF;
                            end else begin
                                count_next = reload_reg - 16'd1;
                            end
                        end
                    end else begin
                        presc_next = presc_inc[pdt_pkg::PRESC_W-1:0];
                    end
                end
            end
            pdt_pkg::OP_WORD_READ: begin
                rvalid_next = 1'b1;
                case (in_reg.offset)
                    pdt_pkg::OFF_RELOAD: rdata_next = reload_reg;
                    pdt_pkg::OFF_COUNT:  rdata_next = count_reg;
                    pdt_pkg::OFF_MODE:   rdata_next = pdt_pkg::MODE_READ_HI | {8'h00, mode_reg};
                    default:             rdata_next = 16'h0000;
                endcase
            end
            pdt_pkg::OP_WORD_WRITE: begin
                case (in_reg.offset)
                    pdt_pkg::OFF_RELOAD: reload_next = in_reg.write_data;
                    pdt_pkg::OFF_MODE:   mode_wr = 1'b1;
                    default:             ;
                endcase
            end
            pdt_pkg::OP_BYTE_WRITE: begin
                case (in_reg.offset)
                    pdt_pkg::OFF_RELOAD:    reload_next = {reload_reg[15:8], new_mode};
                    pdt_pkg::OFF_RELOAD_HI: reload_next = {new_mode, reload_reg[7:0]};
                    pdt_pkg::OFF_MODE:      mode_wr = 1'b1;
                    default:                ;
                endcase
            end
            default: ;
        endcase
        if (mode_wr) begin
            if (!mode_reg[pdt_pkg::M_START] && new_mode[pdt_pkg::M_START]) begin
                count_next = reload_reg;
                presc_next = '0;
            end
            mode_next = new_mode;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            reload_reg    <= pdt_pkg::RELOAD_RESET;
            count_reg     <= pdt_pkg::COUNT_RESET;
            mode_reg      <= 8'h00;
            presc_reg     <= '0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (in_valid_reg && advance) begin
                reload_reg <= reload_next;
                count_reg  <= count_next;
                mode_reg   <= mode_next;
                presc_reg  <= presc_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_reg.opcode     <= s_tuser;
            in_reg.offset     <= s_tdata[2:0];
            in_reg.write_data <= s_tdata[18:3];
        end
        if (in_valid_reg && advance) begin
            rdata_reg  <= rdata_next;
            rvalid_reg <= rvalid_next;
        end
    end

    a_idle_output_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with empty result register");

    a_pending_word_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_reg))
        else $error("stalled input word lost");

    a_nonread_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !rvalid_reg |-> rdata_reg == 16'h0000)
        else $error("non-read result carries data");

    a_stopped_prescaler: assert property (@(posedge aclk) disable iff (!aresetn)
        !mode_reg[pdt_pkg::M_START] && !mode_next[pdt_pkg::M_START] && in_valid_reg && advance
        |=> $stable(presc_reg))
        else $error("prescaler moved while stopped");

endmodule

`default_nettype wire
